>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, sampled on clk_i.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define GDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define GDF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> design/gdf_pkg.sv
// ----------------------------------------------------------------------------
// gdf_pkg
// Types, constants and kernel ROM of the 3x3 Gaussian-derivative filter.
// ----------------------------------------------------------------------------
`default_nettype none

package gdf_pkg;

  localparam int CH_W       = 8;
  localparam int RGB_W      = 3 * CH_W;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int SIZE_RST   = 1024;

  // register indexes of the config port
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // kernel modes
  localparam logic [MODE_W-1:0] MODE_X  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_Y  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_XX = 3'd2;
  localparam logic [MODE_W-1:0] MODE_YY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_XY = 3'd4;

  localparam int ROM_FRAC_BITS = 24;
  localparam int OUT_GAIN      = 10;
  localparam int OUT_OFFSET    = 50;
  localparam int OUT_MAX       = 255;

  // coefficients at 24 fractional bits, [mode][row][col]
  localparam int KERN_RAW [5][3][3] = '{
    '{'{166103, 0, -166103}, '{166935, 0, -166935}, '{166103, 0, -166103}},
    '{'{166103, 166935, 166103}, '{0, 0, 0}, '{-166103, -166935, -166103}},
    '{'{164442, 166935, 164442}, '{165266, 167772, 165266}, '{164442, 166935, 164442}},
    '{'{164442, 165266, 164442}, '{166935, 167772, 166935}, '{164442, 165266, 164442}},
    '{'{16777216, 0, -16777216}, '{0, 0, 0}, '{-16777216, 0, 16777216}}
  };

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // [row][col], col 0 is the oldest column
  typedef rgb_t [2:0][2:0] window_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    window_t win;
    border_t brd;
    logic    last;
  } task_t;

  // raw ROM word; unused modes give an all-zero kernel
  function automatic int kern_raw(input logic [MODE_W-1:0] mode, input int i, input int j);
    if (mode > MODE_XY) return 0;
    return KERN_RAW[mode][i][j];
  endfunction

endpackage

`default_nettype wire

>>> design/gdf_ram.sv
// ----------------------------------------------------------------------------
// gdf_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_q <= mem_q[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

`default_nettype wire

>>> design/gdf_queue.sv
// ----------------------------------------------------------------------------
// gdf_queue
// Small FIFO that decouples window assembly from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

>>> design/gdf_front.sv
// ----------------------------------------------------------------------------
// gdf_front
// Takes pixels, keeps the line stores and the 3x3 window, tracks frame
// position and hands each complete window with its border flags onward.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    img_width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]   img_height_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  gdf_pkg::rgb_t                     pix_i,
  input  logic                              pixel_valid_i,
  input  logic                              full_i,
  output logic                              push_o,
  output gdf_pkg::task_t                    task_o
);

  import gdf_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int ORW = $clog2(MAX_HEIGHT);
  // input row runs one past the height while draining
  localparam int IRW = $clog2(MAX_HEIGHT + 2);

  logic [AW-1:0]  col_q, col_d, ocol_q, ocol_d;
  logic [IRW-1:0] in_row_q, in_row_d;
  logic [ORW-1:0] orow_q, orow_d;
  logic [WW-1:0]  col_inc;
  window_t        win_q, win_d, win_shift;
  logic           byp_q, byp_d;
  rgb_t           byp_up_q, byp_lo_q;
  rgb_t           upper_rd, lower_rd, upper_cur, lower_cur, pix;
  logic           accept, draining, step, out_en;
  border_t        brd;
  logic           frame_last;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign draining   = (in_row_q >= IRW'(img_height_i));
  // a drain tick before the frame is complete is swallowed
  assign step       = accept && (draining || pixel_valid_i);
  assign pix        = draining ? '0 : pix_i;
  assign col_inc    = WW'(col_q) + WW'(1);
  assign out_en     = (in_row_q > IRW'(1)) || ((in_row_q == IRW'(1)) && (col_q != '0));

  assign brd.top    = (orow_q == '0);
  assign brd.bottom = ((HW'(orow_q) + HW'(1)) == img_height_i);
  assign brd.left   = (ocol_q == '0);
  assign brd.right  = ((WW'(ocol_q) + WW'(1)) == img_width_i);
  assign frame_last = brd.bottom && brd.right;

  // line store reads are issued one item ahead; with a one-pixel row the
  // entry just written is read back, so it comes from the bypass
  assign upper_cur = byp_q ? byp_up_q : upper_rd;
  assign lower_cur = byp_q ? byp_lo_q : lower_rd;

  always_comb begin
    col_d    = col_q;
    in_row_d = in_row_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    if (restart_i) begin
      col_d    = '0;
      in_row_d = '0;
      ocol_d   = '0;
      orow_d   = '0;
    end else if (step) begin
      if (col_inc == img_width_i) begin
        col_d    = '0;
        in_row_d = in_row_q + IRW'(1);
      end else begin
        col_d = col_inc[AW-1:0];
      end
      if (out_en) begin
        if (frame_last) begin
          col_d    = '0;
          in_row_d = '0;
          ocol_d   = '0;
          orow_d   = '0;
        end else if (brd.right) begin
          ocol_d = '0;
          orow_d = orow_q + ORW'(1);
        end else begin
          ocol_d = ocol_q + AW'(1);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_shift[i][0] = win_q[i][1];
      win_shift[i][1] = win_q[i][2];
    end
    win_shift[0][2] = upper_cur;
    win_shift[1][2] = lower_cur;
    win_shift[2][2] = pix;
    win_d = step ? win_shift : win_q;
  end

  assign byp_d = step && (col_d == col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      in_row_q <= '0;
      ocol_q   <= '0;
      orow_q   <= '0;
      win_q    <= '0;
      byp_q    <= 1'b0;
    end else begin
      col_q    <= col_d;
      in_row_q <= in_row_d;
      ocol_q   <= ocol_d;
      orow_q   <= orow_d;
      win_q    <= win_d;
      byp_q    <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_up_q <= lower_cur;
    byp_lo_q <= pix;
  end

  gdf_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (col_q),
    .wdata_i (lower_cur),
    .raddr_i (col_d),
    .rdata_o (upper_rd)
  );

  gdf_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_WIDTH)
  ) u_lower_ram (
    .clk_i   (clk_i),
    .we_i    (step),
    .waddr_i (col_q),
    .wdata_i (pix),
    .raddr_i (col_d),
    .rdata_o (lower_rd)
  );

  assign push_o      = step && out_en;
  assign task_o.win  = win_shift;
  assign task_o.brd  = brd;
  assign task_o.last = frame_last;

endmodule

`default_nettype wire

>>> design/gdf_back.sv
// ----------------------------------------------------------------------------
// gdf_back
// Arithmetic pipeline: border replacement and 27 coefficient products,
// row sums, channel sums, then gain, offset and clamp into the output
// register. The whole pipeline holds while the output register is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module gdf_back #(
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [gdf_pkg::MODE_W-1:0]  mode_i,
  input  logic                        task_valid_i,
  input  gdf_pkg::task_t              task_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gdf_pkg::CH_W-1:0]    red_out_o,
  output logic [gdf_pkg::CH_W-1:0]    green_out_o,
  output logic [gdf_pkg::CH_W-1:0]    blue_out_o,
  output logic                        frame_end_o
);

  import gdf_pkg::*;

  localparam int CW    = COEF_FRAC_BITS + 2;
  localparam int PW    = CW + 9;
  localparam int ACC_W = PW + 4;
  localparam int TW    = ACC_W + 5;
  localparam int SW    = TW - COEF_FRAC_BITS;
  localparam int SH    = ROM_FRAC_BITS - COEF_FRAC_BITS;
  localparam int HALF  = (1 << SH) >> 1;
  localparam logic signed [TW-1:0] OFFSET = TW'(OUT_OFFSET) <<< COEF_FRAC_BITS;

  // ROM word rounded to the working precision, ties away from zero
  function automatic logic signed [CW-1:0] coef_q(input logic [MODE_W-1:0] mode,
                                                  input int i, input int j);
    int raw;
    int mag;
    raw = kern_raw(mode, i, j);
    mag = (raw < 0) ? -raw : raw;
    mag = (mag + HALF) >>> SH;
    return (raw < 0) ? CW'(-mag) : CW'(mag);
  endfunction

  logic signed [PW-1:0]    prod_d [3][3][3];
  logic signed [PW-1:0]    prod_q [3][3][3];
  logic signed [ACC_W-1:0] rs_d [3][3];
  logic signed [ACC_W-1:0] rs_q [3][3];
  logic signed [ACC_W-1:0] tot_d [3];
  logic signed [ACC_W-1:0] tot_q [3];
  logic signed [TW-1:0]    t_sum [3];
  logic [CH_W-1:0]         res [3];
  logic                    v1_q, v2_q, v3_q, ov_q;
  logic                    last1_q, last2_q, last3_q, fe_q;
  logic [CH_W-1:0]         red_q, green_q, blue_q;
  logic                    en;

  assign en    = !ov_q || out_ready_i;
  assign pop_o = en && task_valid_i;

  // stage 1: an out-of-frame neighbor takes the center row or column
  always_comb begin
    logic [2:0][CH_W-1:0] px3;
    int si;
    int sj;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        si  = ((i == 0 && task_i.brd.top) || (i == 2 && task_i.brd.bottom)) ? 1 : i;
        sj  = ((j == 0 && task_i.brd.left) || (j == 2 && task_i.brd.right)) ? 1 : j;
        px3 = task_i.win[si][sj];
        for (int ch = 0; ch < 3; ch++) begin
          prod_d[ch][i][j] = PW'(coef_q(mode_i, i, j)) * PW'(signed'({1'b0, px3[ch]}));
        end
      end
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 3; i++) begin
        rs_d[ch][i] = ACC_W'(prod_q[ch][i][0]) + ACC_W'(prod_q[ch][i][1])
                    + ACC_W'(prod_q[ch][i][2]);
      end
    end
  end

  // stage 3: channel sums
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot_d[ch] = rs_q[ch][0] + rs_q[ch][1] + rs_q[ch][2];
    end
  end

  // output: scale, offset, clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      t_sum[ch] = TW'(tot_q[ch]) * TW'(OUT_GAIN) + OFFSET;
      if (t_sum[ch][TW-1]) begin
        res[ch] = '0;
      end else if (t_sum[ch][TW-1:COEF_FRAC_BITS] > SW'(OUT_MAX)) begin
        res[ch] = CH_W'(OUT_MAX);
      end else begin
        res[ch] = t_sum[ch][COEF_FRAC_BITS +: CH_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= task_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      ov_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= prod_d;
      rs_q    <= rs_d;
      tot_q   <= tot_d;
      last1_q <= task_i.last;
      last2_q <= last1_q;
      last3_q <= last2_q;
      fe_q    <= last3_q;
      red_q   <= res[2];
      green_q <= res[1];
      blue_q  <= res[0];
    end
  end

  assign out_valid_o = ov_q;
  assign red_out_o   = red_q;
  assign green_out_o = green_q;
  assign blue_out_o  = blue_q;
  assign frame_end_o = fe_q;

endmodule

`default_nettype wire

>>> design/gaussian_derivative_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// gaussian_derivative_filter_3x3_unit
// 3x3 Gaussian-derivative filter on a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
//
// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+------------------------------------
// in      | in  | in_valid_i / in_ready_o | red/green/blue_in_i, pixel_valid_i
// out     | out | out_valid_o/out_ready_i | red/green/blue_out_o, frame_end_o
// cfg     | in  | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while the output is not stalled. Results are
// registered through the queue and the arithmetic pipeline; the window trails
// the input by one row plus one pixel, flushed by width+1 drain ticks.
// Line store reads are prefetched one column ahead from single-port-read RAMs.
// The line stores are not cleared at reset; no clearing pass is needed.
// A stalled output holds the arithmetic pipeline; a 4-entry queue then fills
// before in_ready_o drops. cfg writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_derivative_filter_3x3_unit #(
  parameter int MAX_WIDTH      = 1024,
  parameter int MAX_HEIGHT     = 1024,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [gdf_pkg::CH_W-1:0]        red_in_i,
  input  logic [gdf_pkg::CH_W-1:0]        green_in_i,
  input  logic [gdf_pkg::CH_W-1:0]        blue_in_i,
  input  logic                            pixel_valid_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gdf_pkg::CH_W-1:0]        red_out_o,
  output logic [gdf_pkg::CH_W-1:0]        green_out_o,
  output logic [gdf_pkg::CH_W-1:0]        blue_out_o,
  output logic                            frame_end_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [gdf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [gdf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import gdf_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (MAX_WIDTH < SIZE_RST) ? MAX_WIDTH : SIZE_RST;
  localparam int H_RST = (MAX_HEIGHT < SIZE_RST) ? MAX_HEIGHT : SIZE_RST;
  localparam int QW    = $bits(task_t);

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [WW-1:0]     width_q, width_d, width_clamp;
  logic [HW-1:0]     height_q, height_d, height_clamp;
  logic              cfg_we, restart;
  rgb_t              pix;
  task_t             push_task, head_task;
  logic [QW-1:0]     head_raw;
  logic              push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // zero reads as one, oversize as the maximum
  assign width_clamp  = (cfg_data_i == '0) ? WW'(1) :
                        (32'(cfg_data_i) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(32'(cfg_data_i));
  assign height_clamp = (cfg_data_i == '0) ? HW'(1) :
                        (32'(cfg_data_i) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(32'(cfg_data_i));

  always_comb begin
    mode_d   = mode_q;
    width_d  = width_q;
    height_d = height_q;
    restart  = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index_i)
        REG_KERNEL_MODE: begin
          mode_d = cfg_data_i[MODE_W-1:0];
        end
        REG_IMAGE_WIDTH: begin
          width_d = width_clamp;
          restart = 1'b1;
        end
        REG_IMAGE_HEIGHT: begin
          height_d = height_clamp;
          restart  = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_X;
      width_q  <= WW'(W_RST);
      height_q <= HW'(H_RST);
    end else begin
      mode_q   <= mode_d;
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign pix.r = red_in_i;
  assign pix.g = green_in_i;
  assign pix.b = blue_in_i;

  gdf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .img_width_i   (width_q),
    .img_height_i  (height_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pix_i         (pix),
    .pixel_valid_i (pixel_valid_i),
    .full_i        (q_full),
    .push_o        (push),
    .task_o        (push_task)
  );

  gdf_queue #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_task),
    .pop_i   (pop),
    .data_o  (head_raw),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign head_task = head_raw;

  gdf_back #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .task_valid_i (!q_empty),
    .task_i       (head_task),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_end_o  (frame_end_o)
  );

endmodule

`default_nettype wire

>>> design/gdf_checker.sv
// ----------------------------------------------------------------------------
// gdf_checker
// Port-level assertions for the filter top level, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gdf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_out_o,
  input logic [7:0] green_out_o,
  input logic [7:0] blue_out_o,
  input logic       frame_end_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o
);

  // a stalled result keeps its value
  `GDF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_out_o) && $stable(green_out_o) && $stable(blue_out_o) && $stable(frame_end_o), "output item changed while stalled")

  // the input side only backs up behind a stalled output
  `GDF_ASSERT(a_in_stall_cause, !in_ready_o |-> $past(out_valid_o && !out_ready_i), "input stalled without output back-pressure")

  `GDF_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !out_valid_o, "output valid right out of reset")

  `GDF_ASSERT_ALWAYS(a_cfg_ready, cfg_valid_i |-> cfg_ready_o, "config write refused")

endmodule

bind gaussian_derivative_filter_3x3_unit gdf_checker u_gdf_checker (.*);

`default_nettype wire
